// File: rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants for the pinhole point projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int POINT_WIDTH_DEF = 32;
  localparam int ADDR_W          = 6;
  localparam int DATA_W          = 64;

  localparam int CART_W = 44;
  localparam int CAM_W  = 48;
  localparam int NORM_W = 32;
  localparam int PIX_W  = 24;
  localparam int FRAC_W = 16;

  localparam logic [47:0] ROT_ROW0_RST     = 48'd16384;
  localparam logic [47:0] ROT_ROW1_RST     = 48'd1073741824;
  localparam logic [47:0] ROT_ROW2_RST     = 48'd70368744177664;
  localparam logic [59:0] TRANSLATION_RST  = 60'd0;
  localparam logic [59:0] INTR_ROW0_RST    = 60'd256;
  localparam logic [59:0] INTR_ROW1_RST    = 60'd268435456;
  localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd480;

  typedef enum logic [1:0] {
    ST_VISIBLE = 2'd0,
    ST_BEHIND  = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_ROT_ROW0     = 3'd0,
    REG_ROT_ROW1     = 3'd1,
    REG_ROT_ROW2     = 3'd2,
    REG_TRANSLATION  = 3'd3,
    REG_INTR_ROW0    = 3'd4,
    REG_INTR_ROW1    = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic w_zero;
    logic z_neg;
    logic z_zero;
  } ppp_flags_t;

endpackage

// File: rtl/pinhole_point_projection.sv
// ----------------------------------------------------------------------------
// pinhole_point_projection
// Projects homogeneous map points through a configured pose and intrinsics.
// ----------------------------------------------------------------------------
// Input words (point_x/y/z/w, signed Q16.16) arrive on in_valid/in_stall and
// are taken at an edge with in_valid high and in_stall low. Each word gives
// exactly one output word (pixel_u, pixel_v in signed Q16.8, status) on
// out_valid/out_stall, in order.
// From the accepting edge to out_valid a word passes the homogeneous divider
// (one quotient bit per stage), the pose multiply-add, the depth divider, the
// intrinsics and one output register. One word is accepted every cycle while
// in_stall is low.
// When the receiver stalls a valid output word, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and restores the registers to an identity
// pose, zero translation, unit intrinsics and a 640x480 image.
// Registers sit on the APB port at byte address 8 * index, 64 bits wide.
// ----------------------------------------------------------------------------
module pinhole_point_projection #(
  parameter int POINT_WIDTH = ppp_pkg::POINT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [POINT_WIDTH-1:0]        point_x,
  input  logic signed [POINT_WIDTH-1:0]        point_y,
  input  logic signed [POINT_WIDTH-1:0]        point_z,
  input  logic signed [POINT_WIDTH-1:0]        point_w,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ppp_pkg::PIX_W-1:0]     pixel_u,
  output logic signed [ppp_pkg::PIX_W-1:0]     pixel_v,
  output logic [1:0]                           status,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ppp_pkg::ADDR_W-1:0]           paddr,
  input  logic [ppp_pkg::DATA_W-1:0]           pwdata,
  output logic [ppp_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);

  import ppp_pkg::*;

  logic [47:0] rot_row [0:2];
  logic [59:0] translation;
  logic [59:0] intr_row [0:1];
  logic [11:0] image_width;
  logic [11:0] image_height;
  reg_idx_t    reg_idx;
  logic        en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0]   <= ROT_ROW0_RST;
      rot_row[1]   <= ROT_ROW1_RST;
      rot_row[2]   <= ROT_ROW2_RST;
      translation  <= TRANSLATION_RST;
      intr_row[0]  <= INTR_ROW0_RST;
      intr_row[1]  <= INTR_ROW1_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROT_ROW0:     rot_row[0]   <= pwdata[47:0];
        REG_ROT_ROW1:     rot_row[1]   <= pwdata[47:0];
        REG_ROT_ROW2:     rot_row[2]   <= pwdata[47:0];
        REG_TRANSLATION:  translation  <= pwdata[59:0];
        REG_INTR_ROW0:    intr_row[0]  <= pwdata[59:0];
        REG_INTR_ROW1:    intr_row[1]  <= pwdata[59:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[11:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[11:0];
        default:          image_height <= image_height;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT_ROW0:     prdata = DATA_W'(rot_row[0]);
      REG_ROT_ROW1:     prdata = DATA_W'(rot_row[1]);
      REG_ROT_ROW2:     prdata = DATA_W'(rot_row[2]);
      REG_TRANSLATION:  prdata = DATA_W'(translation);
      REG_INTR_ROW0:    prdata = DATA_W'(intr_row[0]);
      REG_INTR_ROW1:    prdata = DATA_W'(intr_row[1]);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Homogeneous divide.
  logic [2:0][POINT_WIDTH-1:0] d1_num;
  logic                        d1_vld;
  logic [2:0][CART_W-1:0]      cart;
  logic                        d1_wz;

  assign d1_num = {point_z, point_y, point_x};

  ppp_div #(
    .NW(POINT_WIDTH), .DW(POINT_WIDTH), .QW(CART_W), .FRAC(FRAC_W), .NL(3), .SBW(1)
  ) u_div_w (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .num(d1_num), .den(point_w),
    .side_in(point_w == '0),
    .out_valid(d1_vld), .quo(cart), .side_out(d1_wz)
  );

  // Pose: products, row sums, shift and translate.
  logic signed [59:0] m1_prod [0:2][0:2];
  logic               m1_vld, m1_wz;
  logic signed [61:0] m2_acc [0:2];
  logic               m2_vld, m2_wz;
  logic signed [CAM_W-1:0] cam [0:2];
  logic               m3_vld, m3_wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= d1_vld;
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m1_prod[i][j] <= $signed(rot_row[i][16*j +: 16]) * $signed(cart[j]);
        end
        m2_acc[i] <= 62'(m1_prod[i][0]) + 62'(m1_prod[i][1]) + 62'(m1_prod[i][2]);
        cam[i]    <= $signed(m2_acc[i][61:14])
                   + $signed({{20{translation[20*i+19]}}, translation[20*i +: 20], 8'h00});
      end
      m1_wz <= d1_wz;
      m2_wz <= m1_wz;
      m3_wz <= m2_wz;
    end
  end

  // Depth divide.
  logic [1:0][CAM_W-1:0]  d2_num;
  ppp_flags_t             d2_flags_in;
  ppp_flags_t             d2_flags;
  logic                   d2_vld;
  logic [1:0][NORM_W-1:0] norm;

  assign d2_num             = {cam[1], cam[0]};
  assign d2_flags_in.w_zero = m3_wz;
  assign d2_flags_in.z_neg  = cam[2][CAM_W-1];
  assign d2_flags_in.z_zero = cam[2] == '0;

  ppp_div #(
    .NW(CAM_W), .DW(CAM_W), .QW(NORM_W), .FRAC(FRAC_W), .NL(2), .SBW($bits(ppp_flags_t))
  ) u_div_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(m3_vld), .num(d2_num), .den(cam[2]),
    .side_in(d2_flags_in),
    .out_valid(d2_vld), .quo(norm), .side_out(d2_flags)
  );

  // Intrinsics.
  logic signed [51:0]      k1_prod [0:1][0:1];
  logic signed [37:0]      k2_raw  [0:1];
  logic signed [PIX_W-1:0] k3_pix  [0:1];
  ppp_flags_t              k1_flags, k2_flags, k3_flags;
  logic                    k1_vld, k2_vld, k3_vld;
  logic signed [53:0]      k_sum   [0:1];
  logic                    outside;
  status_t                 status_reg;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      k_sum[r] = 54'(k1_prod[r][0]) + 54'(k1_prod[r][1])
               + 54'($signed({intr_row[r][59:40], 16'h0000}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_vld    <= 1'b0;
      k2_vld    <= 1'b0;
      k3_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      k1_vld    <= d2_vld;
      k2_vld    <= k1_vld;
      k3_vld    <= k2_vld;
      out_valid <= k3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 2; r++) begin
        for (int j = 0; j < 2; j++) begin
          k1_prod[r][j] <= $signed(intr_row[r][20*j +: 20]) * $signed(norm[j]);
        end
        k2_raw[r] <= k_sum[r][53:16];
        if (k2_raw[r][37:23] == {15{k2_raw[r][37]}}) begin
          k3_pix[r] <= k2_raw[r][23:0];
        end else begin
          k3_pix[r] <= k2_raw[r][37] ? {1'b1, 23'h0} : {1'b0, {23{1'b1}}};
        end
      end
      k1_flags <= d2_flags;
      k2_flags <= k1_flags;
      k3_flags <= k2_flags;
    end
  end

  assign outside = k3_pix[0][PIX_W-1] || k3_pix[1][PIX_W-1]
                || (k3_pix[0][PIX_W-2:0] >= {3'b000, image_width, 8'h00})
                || (k3_pix[1][PIX_W-2:0] >= {3'b000, image_height, 8'h00});

  always_ff @(posedge clk) begin
    if (en) begin
      if (k3_flags.w_zero || (!k3_flags.z_neg && k3_flags.z_zero)) begin
        pixel_u    <= '0;
        pixel_v    <= '0;
        status_reg <= ST_INVALID;
      end else if (k3_flags.z_neg) begin
        pixel_u    <= '0;
        pixel_v    <= '0;
        status_reg <= ST_BEHIND;
      end else begin
        pixel_u    <= k3_pix[0];
        pixel_v    <= k3_pix[1];
        status_reg <= outside ? ST_OUTSIDE : ST_VISIBLE;
      end
    end
  end

  assign status = status_reg;

endmodule

// File: rtl/ppp_div.sv
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined saturating divider, one quotient bit per stage, several lanes
// sharing one divisor. Gives trunc(num * 2^FRAC / den) saturated to QW bits.
// ----------------------------------------------------------------------------
module ppp_div #(
  parameter int NW   = 32,
  parameter int DW   = 32,
  parameter int QW   = 44,
  parameter int FRAC = 16,
  parameter int NL   = 3,
  parameter int SBW  = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [NL-1:0][NW-1:0]  num,
  input  logic [DW-1:0]          den,
  input  logic [SBW-1:0]         side_in,
  output logic                   out_valid,
  output logic [NL-1:0][QW-1:0]  quo,
  output logic [SBW-1:0]         side_out
);

  localparam int MW = NW + FRAC;
  localparam int XW = ((MW > QW) ? MW : QW) + 1;
  localparam int HW = XW - QW;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

  logic [NL-1:0][NW-1:0] a_mag;
  logic [NL-1:0]         a_neg;
  logic [DW-1:0]         a_den;
  logic [SBW-1:0]        a_side;
  logic                  a_vld;

  logic [NL-1:0][DW-1:0] rem  [0:QW];
  logic [NL-1:0][QW-1:0] bits [0:QW];
  logic [DW-1:0]         dv   [0:QW];
  logic [NL-1:0]         neg  [0:QW];
  logic [NL-1:0]         ovf  [0:QW];
  logic [SBW-1:0]        sb   [0:QW];
  logic                  vld  [0:QW];

  logic [NL-1:0][XW-1:0] b_dx;
  logic [NL-1:0][CW-1:0] b_hx;
  logic [NL-1:0][DW-1:0] b_rem;
  logic [NL-1:0][QW-1:0] b_bits;
  logic [NL-1:0]         b_ovf;

  logic [NL-1:0][QW-1:0] c_q;
  logic [NL-1:0]         c_neg;
  logic [SBW-1:0]        c_side;
  logic                  c_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        a_mag[l] <= num[l][NW-1] ? (~num[l] + NW'(1)) : num[l];
        a_neg[l] <= num[l][NW-1] ^ den[DW-1];
      end
      a_den  <= den[DW-1] ? (~den + DW'(1)) : den;
      a_side <= side_in;
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      b_dx[l]   = XW'(a_mag[l]) << FRAC;
      b_hx[l]   = CW'(b_dx[l][XW-1:QW]);
      b_ovf[l]  = b_hx[l] >= CW'(a_den);
      b_rem[l]  = b_hx[l][DW-1:0];
      b_bits[l] = b_dx[l][QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= b_rem;
      bits[0] <= b_bits;
      dv[0]   <= a_den;
      neg[0]  <= a_neg;
      ovf[0]  <= b_ovf;
      sb[0]   <= a_side;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [NL-1:0][DW:0]   tr;
    logic [NL-1:0][DW:0]   df;
    logic [NL-1:0][DW-1:0] r_next;
    logic [NL-1:0][QW-1:0] q_next;

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        tr[l] = {rem[k-1][l], bits[k-1][l][QW-1]};
        df[l] = tr[l] - {1'b0, dv[k-1]};
        if (tr[l] >= {1'b0, dv[k-1]}) begin
          r_next[l] = df[l][DW-1:0];
          q_next[l] = {bits[k-1][l][QW-2:0], 1'b1};
        end else begin
          r_next[l] = tr[l][DW-1:0];
          q_next[l] = {bits[k-1][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= r_next;
        bits[k] <= q_next;
        dv[k]   <= dv[k-1];
        neg[k]  <= neg[k-1];
        ovf[k]  <= ovf[k-1];
        sb[k]   <= sb[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c_vld     <= vld[QW];
      out_valid <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        if (neg[QW][l]) begin
          c_q[l] <= (ovf[QW][l] || bits[QW][l] > LIM_NEG) ? LIM_NEG : bits[QW][l];
        end else begin
          c_q[l] <= (ovf[QW][l] || bits[QW][l] > LIM_POS) ? LIM_POS : bits[QW][l];
        end
        quo[l] <= c_neg[l] ? (~c_q[l] + QW'(1)) : c_q[l];
      end
      c_neg    <= neg[QW];
      c_side   <= sb[QW];
      side_out <= c_side;
    end
  end

endmodule

// File: rtl/ppp_checker.sv
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks for the pinhole point projection, bound to the top level.
// ----------------------------------------------------------------------------
module ppp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [23:0] pixel_u,
  input logic signed [23:0] pixel_v,
  input logic [1:0]        status
);

  import ppp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_u) && $stable(pixel_v)
      && $stable(status))
    else $error("Stalled output word changed.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled without a stalled output word.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_INVALID |-> pixel_u == '0 && pixel_v == '0)
    else $error("Invalid point reported nonzero pixels.");

  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BEHIND |-> pixel_u == '0 && pixel_v == '0)
    else $error("Point behind camera reported nonzero pixels.");

endmodule

bind pinhole_point_projection ppp_checker u_ppp_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .pixel_u(pixel_u), .pixel_v(pixel_v), .status(status)
);

// File: verif/pinhole_point_projection_tb.sv
// ----------------------------------------------------------------------------
// pinhole_point_projection_tb
// Streams map points through the projection pipeline under several camera
// setups and compares every output word with a fixed-point predictor.
// ----------------------------------------------------------------------------
module pinhole_point_projection_tb;
  import ppp_pkg::*;

  typedef struct {
    logic [23:0] u;
    logic [23:0] v;
    status_t     st;
  } pixel_word_t;

  class projection_scoreboard;
    logic [63:0] cam_regs [8];
    pixel_word_t pending_pixels [$];
    int errors;

    function new();
      cam_regs[REG_ROT_ROW0]     = ROT_ROW0_RST;
      cam_regs[REG_ROT_ROW1]     = ROT_ROW1_RST;
      cam_regs[REG_ROT_ROW2]     = ROT_ROW2_RST;
      cam_regs[REG_TRANSLATION]  = TRANSLATION_RST;
      cam_regs[REG_INTR_ROW0]    = INTR_ROW0_RST;
      cam_regs[REG_INTR_ROW1]    = INTR_ROW1_RST;
      cam_regs[REG_IMAGE_WIDTH]  = IMAGE_WIDTH_RST;
      cam_regs[REG_IMAGE_HEIGHT] = IMAGE_HEIGHT_RST;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] val);
      int bits;
      bits = (idx <= REG_ROT_ROW2) ? 48 : (idx <= REG_INTR_ROW1) ? 60 : 12;
      cam_regs[idx] = val & ((64'd1 << bits) - 64'd1);
    endfunction

    function longint sx(logic [63:0] v, int bits);
      return longint'(v << (64 - bits)) >>> (64 - bits);
    endfunction

    function longint div_sat(longint n, longint d, int outbits);
      bit neg;
      longint unsigned un, ud, q, lim;
      neg = (n < 0) != (d < 0);
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (un << 16) / ud;
      lim = 64'd1 << (outbits - 1);
      if (!neg) lim = lim - 1;
      if (q > lim) q = lim;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function pixel_word_t project_point(logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [31:0] w);
      pixel_word_t r;
      longint p [3], c [3], cam [3], acc, wv, nx, ny, pu, pv;
      r.u = 0;
      r.v = 0;
      p[0] = sx(x, 32);
      p[1] = sx(y, 32);
      p[2] = sx(z, 32);
      wv = sx(w, 32);
      if (wv == 0) begin
        r.st = ST_INVALID;
        return r;
      end
      for (int i = 0; i < 3; i++) c[i] = div_sat(p[i], wv, 44);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += sx(cam_regs[i] >> (16 * j), 16) * c[j];
        cam[i] = (acc >>> 14) + sx(cam_regs[REG_TRANSLATION] >> (20 * i), 20) * 256;
      end
      if (cam[2] < 0) begin
        r.st = ST_BEHIND;
        return r;
      end
      if (cam[2] == 0) begin
        r.st = ST_INVALID;
        return r;
      end
      nx = div_sat(cam[0], cam[2], 32);
      ny = div_sat(cam[1], cam[2], 32);
      pu = sat24((sx(cam_regs[REG_INTR_ROW0], 20) * nx
                + sx(cam_regs[REG_INTR_ROW0] >> 20, 20) * ny
                + sx(cam_regs[REG_INTR_ROW0] >> 40, 20) * 65536) >>> 16);
      pv = sat24((sx(cam_regs[REG_INTR_ROW1], 20) * nx
                + sx(cam_regs[REG_INTR_ROW1] >> 20, 20) * ny
                + sx(cam_regs[REG_INTR_ROW1] >> 40, 20) * 65536) >>> 16);
      r.st = ST_VISIBLE;
      if (pu < 0 || pu >= longint'(cam_regs[REG_IMAGE_WIDTH]) * 256 ||
          pv < 0 || pv >= longint'(cam_regs[REG_IMAGE_HEIGHT]) * 256)
        r.st = ST_OUTSIDE;
      r.u = pu[23:0];
      r.v = pv[23:0];
      return r;
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [31:0] w);
      pending_pixels.push_back(project_point(x, y, z, w));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(logic [23:0] u, logic [23:0] v, logic [1:0] st);
      pixel_word_t e;
      if (pending_pixels.size() == 0) begin
        report("output word with nothing expected");
      end else begin
        e = pending_pixels.pop_front();
        if (u !== e.u) report($sformatf("pixel_u %h expected %h", u, e.u));
        if (v !== e.v) report($sformatf("pixel_v %h expected %h", v, e.v));
        if (st !== e.st) report($sformatf("status %0d expected %0d", st, e.st));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0, point_w = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [23:0] pixel_u, pixel_v;
  logic [1:0] status;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [DATA_W-1:0] pwdata = 0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  projection_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  pinhole_point_projection u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y), .point_z(point_z), .point_w(point_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_u(pixel_u), .pixel_v(pixel_v), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_pixel(pixel_u, pixel_v, status);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(1, 30);
      out_stall <= 0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= 1;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  task write_reg(reg_idx_t idx, logic [63:0] val);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= ADDR_W'(8 * idx);
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    point_w <= w;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_point(x, y, z, w);
  endtask

  task send_random_point();
    int r, m;
    logic signed [31:0] cx, cy, cz;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      cz = $urandom_range(1 << 16, 50 << 16);
      cx = $signed($urandom_range(0, 2 * cz)) - cz;
      cy = $signed($urandom_range(0, 2 * cz)) - cz;
      m = $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) m = -m;
      send_point(cx * m, cy * m, cz * m, 32'sd65536 * m);
    end else if (r < 85) begin
      cz = $urandom_range(1, 50 << 16);
      send_point($urandom, $urandom, -cz, 32'sd65536);
    end else if (r < 88) begin
      send_point($urandom, $urandom, $urandom, 0);
    end else begin
      send_point($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task drain();
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function logic [63:0] pack3(int bits, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [63:0] m;
    m = (64'd1 << bits) - 1;
    return (a & m) | ((c & m) << (2 * bits)) | ((b & m) << bits);
  endfunction

  task camera_setup(int kind);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    case (kind)
      1: begin
        write_reg(REG_ROT_ROW0, pack3(16, 16384, 0, 0));
        write_reg(REG_ROT_ROW1, pack3(16, 0, 16384, 0));
        write_reg(REG_ROT_ROW2, pack3(16, 0, 0, 16384));
        write_reg(REG_TRANSLATION, pack3(20, 256, -512, 1024));
        write_reg(REG_INTR_ROW0, pack3(20, 500 * 256, 0, 320 * 256));
        write_reg(REG_INTR_ROW1, pack3(20, 0, 500 * 256, 240 * 256));
        write_reg(REG_IMAGE_WIDTH, 640);
        write_reg(REG_IMAGE_HEIGHT, 480);
      end
      2: begin
        for (int i = 0; i < 8; i++) write_reg(reg_idx_t'(i), {$urandom, $urandom});
      end
      3: begin
        for (int i = 0; i < 6; i++) write_reg(reg_idx_t'(i), 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_IMAGE_WIDTH, 4095 | (junk << 12));
        write_reg(REG_IMAGE_HEIGHT, 4095);
      end
      4: begin
        for (int i = 0; i < 3; i++)
          write_reg(reg_idx_t'(i), pack3(16, 32'h8000, 32'h8000, 32'h8000) | (junk << 48));
        for (int i = 3; i < 6; i++)
          write_reg(reg_idx_t'(i), pack3(20, 32'h80000, 32'h80000, 32'h80000));
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 1);
      end
      default: begin
        write_reg(REG_ROT_ROW0, pack3(16, 11585, -11585, 0));
        write_reg(REG_ROT_ROW1, pack3(16, 11585, 11585, 0));
        write_reg(REG_ROT_ROW2, pack3(16, 0, 0, 16384));
        write_reg(REG_TRANSLATION, pack3(20, 0, 0, 2560));
        write_reg(REG_INTR_ROW0, pack3(20, 1000 * 256, 0, 2048 * 256));
        write_reg(REG_INTR_ROW1, pack3(20, 0, 1000 * 256, 1024 * 256));
        write_reg(REG_IMAGE_WIDTH, 4095);
        write_reg(REG_IMAGE_HEIGHT, 2047);
      end
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_point(0, 0, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_point(0, 0, 0, 32'sd65536);
    send_point(65536, 65536, -65536, 32'sd65536);
    send_point(65536, 32768, 131072, 32'sd65536);
    send_point(0, 0, 65536, 32'sd65536);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 1, 1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_point(-65536, -65536, 65536, 32'sd65536);
    send_point(500 << 16, 300 << 16, 1, 32'sd65536);
    send_point(65536, 65536, 65536, -32'sd65536);
    drain();
    camera_setup(1);
    send_point(0, 0, 65536, 32'sd65536);
    send_point(1 << 16, 1 << 16, 1 << 16, 32'sd65536);
    send_point(-(1 << 20), 0, 1 << 16, 32'sd65536);
    send_point(0, 0, -(4 << 16), 32'sd65536);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        camera_setup(ph);
      end
      for (int n = 0; n < 210; n++) send_random_point();
    end
    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
